/* rtl/core/itp_pkg.sv */
`default_nettype none
package itp_pkg;

    localparam logic [7:0] C_CARET = 8'h5E;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_NUL   = 8'h00;

    localparam int unsigned STACK_DEPTH = 3;

    // output character source
    localparam logic [1:0] SEL_INPUT = 2'd0;
    localparam logic [1:0] SEL_TOP   = 2'd1;
    localparam logic [1:0] SEL_NUL   = 2'd2;

    typedef logic [1:0] t_rank;
    typedef logic [1:0] t_count;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [1:0] emit_sel;
        logic       emit_last;
        logic       pop;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic in_letter;
        logic in_op;
        logic cur_end;
        logic top_ge;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic out_free;
        logic any_emitted;
    } t_status;

    function automatic t_rank rank_of(input logic [7:0] c);
        t_rank r;
        r = 2'd0;
        if (c == C_CARET) r = 2'd3;
        else if (c == C_STAR || c == C_SLASH) r = 2'd2;
        else if (c == C_PLUS || c == C_MINUS) r = 2'd1;
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/infix_to_postfix_converter.sv */
// One item at a time: an accept step, then an emit step for each output character
// (the operator pop/flush loop in the controller), plus a push step for
// an operator, or a decode step for an ignored character that emits nothing.
// Emit steps wait while the output register holds a character that is not taken.
// Results leave through a single output register.
// Reset: synchronous, active low; clears the stack count, state and output valid.
`default_nettype none
module infix_to_postfix_converter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_expression,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_char,
    output logic            o_last
);

    itp_pkg::t_cmd    cmd;
    itp_pkg::t_status status;

    itp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itp_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_in_char           (i_in_char),
        .i_end_of_expression (i_end_of_expression),
        .i_out_ready         (i_ready),
        .o_out_valid         (o_valid),
        .o_out_char          (o_out_char),
        .o_last              (o_last)
    );

endmodule
`default_nettype wire

/* rtl/core/itp_datapath.sv */
`default_nettype none
module itp_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire itp_pkg::t_cmd     i_cmd,
    output itp_pkg::t_status       o_status,
    input  wire logic [7:0]        i_in_char,
    input  wire logic              i_end_of_expression,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_out_char,
    output logic                   o_last
);

    logic [7:0]      r_stack [itp_pkg::STACK_DEPTH];
    itp_pkg::t_count r_count;
    itp_pkg::t_count n_count;
    logic [7:0]      r_char;
    logic            r_end;
    logic            r_any;
    logic            r_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;
    logic [7:0]      top;
    logic [7:0]      emit_char;
    logic            out_free;

    always_comb begin
        case (r_count)
            2'd1:    top = r_stack[0];
            2'd2:    top = r_stack[1];
            2'd3:    top = r_stack[2];
            default: top = itp_pkg::C_NUL;
        endcase
    end

    always_comb begin
        case (i_cmd.emit_sel)
            itp_pkg::SEL_INPUT: emit_char = r_char;
            itp_pkg::SEL_TOP:   emit_char = top;
            default:            emit_char = itp_pkg::C_NUL;
        endcase
    end

    assign out_free = !r_valid || i_out_ready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.pop)       n_count = r_count - 2'd1;
        else if (i_cmd.push) n_count = r_count + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit)          r_valid <= 1'b1;
            else if (i_out_ready)    r_valid <= 1'b0;
            if (i_cmd.accept)        r_any   <= 1'b0;
            else if (i_cmd.emit)     r_any   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in_char;
            r_end  <= i_end_of_expression;
        end
        if (i_cmd.push) begin
            r_stack[r_count] <= r_char;
        end
        if (i_cmd.emit) begin
            r_out_char <= emit_char;
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_status.in_letter   = itp_pkg::is_letter(i_in_char);
        o_status.in_op       = itp_pkg::rank_of(i_in_char) != 2'd0;
        o_status.cur_end     = r_end;
        o_status.top_ge      = (r_count != 2'd0) &&
                               (itp_pkg::rank_of(top) >= itp_pkg::rank_of(r_char));
        o_status.cnt_zero    = r_count == 2'd0;
        o_status.cnt_one     = r_count == 2'd1;
        o_status.cnt_full    = r_count == 2'(itp_pkg::STACK_DEPTH);
        o_status.out_free    = out_free;
        o_status.any_emitted = r_any;
    end

    assign o_out_valid = r_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

/* rtl/core/itp_controller.sv */
`default_nettype none
module itp_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire itp_pkg::t_status  i_status,
    output itp_pkg::t_cmd          o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LETTER = 2'd1;
    localparam logic [1:0] S_POP    = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_sel  = itp_pkg::SEL_INPUT;
        o_cmd.emit_last = 1'b0;
        o_cmd.pop       = 1'b0;
        o_cmd.push      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // classify on the incoming character
                    if (i_status.in_letter)  n_state = S_LETTER;
                    else if (i_status.in_op) n_state = S_POP;
                    else                     n_state = S_FLUSH;
                end
            end
            S_LETTER: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = itp_pkg::SEL_INPUT;
                    o_cmd.emit_last = i_status.cur_end && i_status.cnt_zero;
                    n_state = (i_status.cur_end && !i_status.cnt_zero) ? S_FLUSH : S_IDLE;
                end
            end
            S_POP: begin
                if (i_status.top_ge) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = itp_pkg::SEL_TOP;
                        o_cmd.pop      = 1'b1;
                    end
                end else begin
                    o_cmd.push = !i_status.cnt_full;
                    n_state    = i_status.cur_end ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!i_status.cur_end) begin
                    n_state = S_IDLE;
                end else if (!i_status.cnt_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_sel  = itp_pkg::SEL_TOP;
                        o_cmd.emit_last = i_status.cnt_one;
                        o_cmd.pop       = 1'b1;
                        if (i_status.cnt_one) n_state = S_IDLE;
                    end
                end else if (i_status.any_emitted) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    // end item produced nothing: send the empty marker
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = itp_pkg::SEL_NUL;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire
